// ===== hw/rtl/lrucache_pkg.sv =====
`timescale 1ns / 1ps

package lrucache_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;

  localparam logic [1:0] OP_IFETCH = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_STORE  = 2'd2;
  localparam logic [1:0] OP_MODIFY = 2'd3;

  localparam logic [1:0] CFG_SET_INDEX_BITS    = 2'd0;
  localparam logic [1:0] CFG_BLOCK_OFFSET_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS_IN_USE       = 2'd2;

  localparam logic [2:0] SET_INDEX_BITS_RESET    = 3'd4;
  localparam logic [5:0] BLOCK_OFFSET_BITS_RESET = 6'd4;
  localparam logic [3:0] WAYS_IN_USE_RESET       = 4'd1;

  typedef struct packed {
    logic hit;
    logic miss;
    logic evict;
  } bump_t;

endpackage

// ===== hw/rtl/lrucache_ram.sv =====
`timescale 1ns / 1ps

module lrucache_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lrucache_split.sv =====
`timescale 1ns / 1ps

module lrucache_split #(
  parameter int MAX_SET_BITS = lrucache_pkg::MAX_SET_BITS,
  parameter int SB = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  logic [63:0]   address,
  input  logic [2:0]    set_index_bits,
  input  logic [5:0]    block_offset_bits,
  output logic [SB-1:0] set,
  output logic [63:0]   tag
);

  logic [2:0]    sbits;
  logic [6:0]    sh;
  logic [63:0]   shifted;
  logic [SB-1:0] mask;

  always_comb begin
    sbits = (int'(set_index_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_index_bits;
    sh = 7'(block_offset_bits) + 7'(sbits);
    shifted = address >> block_offset_bits;
    for (int i = 0; i < SB; i++) begin
      mask[i] = (i < int'(sbits));
    end
    set = shifted[SB-1:0] & mask;
    tag = sh[6] ? 64'd0 : (address >> sh[5:0]);
  end

endmodule

// ===== hw/rtl/lrucache_totals.sv =====
`timescale 1ns / 1ps

module lrucache_totals (
  input  logic                clk,
  input  logic                rst,
  input  lrucache_pkg::bump_t bump,
  output logic [31:0]         total_hits,
  output logic [31:0]         total_misses,
  output logic [31:0]         total_evictions
);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_hits      <= '0;
      total_misses    <= '0;
      total_evictions <= '0;
    end else begin
      if (bump.hit && total_hits != '1) begin
        total_hits <= total_hits + 32'd1;
      end
      if (bump.miss && total_misses != '1) begin
        total_misses <= total_misses + 32'd1;
      end
      if (bump.evict && total_evictions != '1) begin
        total_evictions <= total_evictions + 32'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/lru_set_assoc_cache_tag_sim_top.sv =====
`timescale 1ns / 1ps

// Trace-driven tag simulator of a set-associative cache with least recently used
// replacement. Each accepted access (op, address) yields exactly one result with the
// hits, misses and evictions it caused and the saturating running totals. A lookup
// walks the ways of the selected set one per cycle through a single shared tag
// comparator, reading the tags from a RAM, and then updates the valid bits and ranks
// of the set in one row write. An instruction fetch goes straight to finish, a load
// or store passes through split, scan, update and finish, and a modify runs scan and
// update twice; the block then returns to idle before it takes the next access.
// A finished result that meets a previous result still held by out_stall waits in
// the last state until that one is taken. After reset the block clears all
// 2^MAX_SET_BITS sets, one set per cycle, before it accepts the first access;
// configuration writes are taken at any time but belong in idle periods.
module lru_set_assoc_cache_tag_sim_top #(
  parameter int MAX_SET_BITS = lrucache_pkg::MAX_SET_BITS,
  parameter int MAX_WAYS     = lrucache_pkg::MAX_WAYS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [63:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  hits,
  output logic [1:0]  misses,
  output logic [1:0]  evictions,
  output logic [31:0] total_hits,
  output logic [31:0] total_misses,
  output logic [31:0] total_evictions
);

  localparam int SB    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WB    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RB    = WB;
  localparam int CW    = $clog2(MAX_WAYS + 1);
  localparam int XW    = (CW > 4) ? CW : 4;
  localparam int ROW_W = MAX_WAYS * (RB + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SPLIT,
    S_SCAN,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t state;

  logic [2:0] set_index_bits;
  logic [5:0] block_offset_bits;
  logic [3:0] ways_in_use;

  logic [1:0]    cur_op;
  logic [63:0]   cur_addr;
  logic [SB-1:0] cur_set;
  logic [63:0]   cur_tag;
  logic          second;
  logic [SB-1:0] clr_cnt;

  logic [WB-1:0] scan_way;
  logic          issuing;
  logic          rd_pending;
  logic [WB-1:0] rd_way;

  logic          found;
  logic [WB-1:0] best_way;
  logic [RB-1:0] best_rank;
  logic          old_found;
  logic [WB-1:0] old_way;
  logic [RB-1:0] old_rank;
  logic          free_found;
  logic [WB-1:0] free_way;
  logic [CW-1:0] count;

  logic [1:0] acc_hits;
  logic [1:0] acc_misses;
  logic [1:0] acc_evictions;

  logic [SB-1:0]    split_set;
  logic [63:0]      split_tag;
  logic [ROW_W-1:0] row_rd;
  logic [ROW_W-1:0] row_wr;
  logic             row_we;
  logic [SB-1:0]    row_waddr;
  logic [63:0]      tag_rd;
  logic             tag_we;
  logic [WB-1:0]    ins_way;

  logic [MAX_WAYS-1:0]         rd_valid;
  logic [RB-1:0]               rd_rank [MAX_WAYS];
  logic [MAX_WAYS-1:0]         new_valid;
  logic [RB-1:0]               new_rank [MAX_WAYS];
  logic                        cur_valid;
  logic [RB-1:0]               cur_rank;
  logic                        cur_match;
  logic [XW-1:0]               ways_eff;
  logic                        evict_case;
  lrucache_pkg::bump_t         bump;
  logic [31:0]                 sum_hits;
  logic [31:0]                 sum_misses;
  logic [31:0]                 sum_evictions;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits    <= lrucache_pkg::SET_INDEX_BITS_RESET;
      block_offset_bits <= lrucache_pkg::BLOCK_OFFSET_BITS_RESET;
      ways_in_use       <= lrucache_pkg::WAYS_IN_USE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrucache_pkg::CFG_SET_INDEX_BITS:    set_index_bits    <= cfg_data[2:0];
        lrucache_pkg::CFG_BLOCK_OFFSET_BITS: block_offset_bits <= cfg_data;
        lrucache_pkg::CFG_WAYS_IN_USE:       ways_in_use       <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  lrucache_split #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .SB          (SB)
  ) u_split (
    .address          (cur_addr),
    .set_index_bits   (set_index_bits),
    .block_offset_bits(block_offset_bits),
    .set              (split_set),
    .tag              (split_tag)
  );

  lrucache_ram #(
    .DATA_W(ROW_W),
    .ADDR_W(SB)
  ) u_row_ram (
    .clk  (clk),
    .we   (row_we),
    .waddr(row_waddr),
    .wdata(row_wr),
    .raddr(cur_set),
    .rdata(row_rd)
  );

  lrucache_ram #(
    .DATA_W(64),
    .ADDR_W(SB + WB)
  ) u_tag_ram (
    .clk  (clk),
    .we   (tag_we),
    .waddr({cur_set, ins_way}),
    .wdata(cur_tag),
    .raddr({cur_set, scan_way}),
    .rdata(tag_rd)
  );

  lrucache_totals u_totals (
    .clk            (clk),
    .rst            (rst),
    .bump           (bump),
    .total_hits     (sum_hits),
    .total_misses   (sum_misses),
    .total_evictions(sum_evictions)
  );

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      rd_valid[w] = row_rd[w];
      rd_rank[w]  = row_rd[MAX_WAYS + w*RB +: RB];
    end
    cur_valid = rd_valid[rd_way];
    cur_rank  = rd_rank[rd_way];
    cur_match = (tag_rd == cur_tag);

    ways_eff = (XW'(ways_in_use) > XW'(MAX_WAYS)) ? XW'(MAX_WAYS) : XW'(ways_in_use);
    evict_case = (XW'(count) >= ways_eff);

    new_valid = rd_valid;
    new_rank  = rd_rank;
    tag_we    = 1'b0;
    ins_way   = evict_case ? old_way : free_way;
    if (found) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (rd_valid[w] && rd_rank[w] < best_rank) begin
          new_rank[w] = rd_rank[w] + RB'(1);
        end
      end
      new_rank[best_way] = '0;
    end else if (!evict_case || count != '0) begin
      if (evict_case) begin
        new_valid[old_way] = 1'b0;
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (new_valid[w]) begin
          new_rank[w] = rd_rank[w] + RB'(1);
        end
      end
      new_valid[ins_way] = 1'b1;
      new_rank[ins_way]  = '0;
      tag_we = (state == S_UPDATE);
    end

    row_we    = (state == S_CLEAR) || (state == S_UPDATE);
    row_waddr = (state == S_CLEAR) ? clr_cnt : cur_set;
    row_wr    = '0;
    if (state == S_UPDATE) begin
      row_wr[MAX_WAYS-1:0] = new_valid;
      for (int w = 0; w < MAX_WAYS; w++) begin
        row_wr[MAX_WAYS + w*RB +: RB] = new_rank[w];
      end
    end

    bump.hit   = (state == S_UPDATE) && found;
    bump.miss  = (state == S_UPDATE) && !found;
    bump.evict = (state == S_UPDATE) && !found && evict_case;

    in_stall = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == SB'((1 << MAX_SET_BITS) - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + SB'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cur_op        <= op;
            cur_addr      <= address;
            second        <= 1'b0;
            acc_hits      <= '0;
            acc_misses    <= '0;
            acc_evictions <= '0;
            state <= (op == lrucache_pkg::OP_IFETCH) ? S_FINISH : S_SPLIT;
          end
        end
        S_SPLIT: begin
          cur_set    <= split_set;
          cur_tag    <= split_tag;
          scan_way   <= '0;
          issuing    <= 1'b1;
          rd_pending <= 1'b0;
          found      <= 1'b0;
          old_found  <= 1'b0;
          free_found <= 1'b0;
          count      <= '0;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          if (issuing) begin
            rd_pending <= 1'b1;
            rd_way     <= scan_way;
            if (scan_way == WB'(MAX_WAYS - 1)) begin
              issuing <= 1'b0;
            end else begin
              scan_way <= scan_way + WB'(1);
            end
          end else begin
            rd_pending <= 1'b0;
          end
          if (rd_pending) begin
            if (cur_valid) begin
              count <= count + CW'(1);
              if (cur_match && (!found || cur_rank < best_rank)) begin
                found     <= 1'b1;
                best_way  <= rd_way;
                best_rank <= cur_rank;
              end
              if (!old_found || cur_rank > old_rank) begin
                old_found <= 1'b1;
                old_way   <= rd_way;
                old_rank  <= cur_rank;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_way   <= rd_way;
            end
            if (rd_way == WB'(MAX_WAYS - 1)) begin
              state <= S_UPDATE;
            end
          end
        end
        S_UPDATE: begin
          acc_hits      <= acc_hits + 2'(bump.hit);
          acc_misses    <= acc_misses + 2'(bump.miss);
          acc_evictions <= acc_evictions + 2'(bump.evict);
          if (cur_op == lrucache_pkg::OP_MODIFY && !second) begin
            second     <= 1'b1;
            scan_way   <= '0;
            issuing    <= 1'b1;
            rd_pending <= 1'b0;
            found      <= 1'b0;
            old_found  <= 1'b0;
            free_found <= 1'b0;
            count      <= '0;
            state      <= S_SCAN;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            hits            <= acc_hits;
            misses          <= acc_misses;
            evictions       <= acc_evictions;
            total_hits      <= sum_hits;
            total_misses    <= sum_misses;
            total_evictions <= sum_evictions;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== test/lru_cache_checker.sv =====
`timescale 1ns / 1ps

module lru_cache_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  op,
  input  logic [63:0] address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  hits,
  input  logic [1:0]  misses,
  input  logic [1:0]  evictions,
  input  logic [31:0] total_hits,
  input  logic [31:0] total_misses,
  input  logic [31:0] total_evictions,
  output int          errors,
  output int          pending,
  output int          checked
);

  localparam int MAX_SET_BITS = lrucache_pkg::MAX_SET_BITS;
  localparam int MAX_WAYS     = lrucache_pkg::MAX_WAYS;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;

  typedef struct packed {
    logic [1:0]  hits;
    logic [1:0]  misses;
    logic [1:0]  evictions;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_evictions;
  } access_outcome_t;

  logic        line_ok  [NUM_SETS][MAX_WAYS];
  logic [63:0] line_tag [NUM_SETS][MAX_WAYS];
  int          line_age [NUM_SETS][MAX_WAYS];
  logic [31:0] sum_hits;
  logic [31:0] sum_misses;
  logic [31:0] sum_evictions;
  int          cfg_sets;
  int          cfg_off;
  int          cfg_ways;
  int          n_errors;
  int          n_checked;
  access_outcome_t outcome_q [$];

  task automatic cache_access(input logic [63:0] addr, inout int h, inout int m,
                              inout int e);
    int          sb;
    int          bb;
    int          nw;
    int          sh;
    int          set_i;
    int          cnt;
    int          hit_w;
    int          old_w;
    int          free_w;
    int          r;
    logic [63:0] tg;
    sb = (cfg_sets > MAX_SET_BITS) ? MAX_SET_BITS : cfg_sets;
    bb = cfg_off;
    nw = (cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways;
    set_i = int'((addr >> bb) & ((64'd1 << sb) - 64'd1));
    sh = bb + sb;
    tg = (sh >= 64) ? 64'd0 : (addr >> sh);
    cnt = 0;
    hit_w = -1;
    old_w = -1;
    free_w = -1;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (line_ok[set_i][w]) begin
        cnt++;
        if (line_tag[set_i][w] == tg &&
            (hit_w < 0 || line_age[set_i][w] < line_age[set_i][hit_w]))
          hit_w = w;
        if (old_w < 0 || line_age[set_i][w] > line_age[set_i][old_w])
          old_w = w;
      end else if (free_w < 0) begin
        free_w = w;
      end
    end

    if (hit_w >= 0) begin
      h++;
      if (sum_hits != '1) sum_hits++;
      r = line_age[set_i][hit_w];
      for (int w = 0; w < MAX_WAYS; w++)
        if (line_ok[set_i][w] && line_age[set_i][w] < r) line_age[set_i][w]++;
      line_age[set_i][hit_w] = 0;
      return;
    end

    m++;
    if (sum_misses != '1) sum_misses++;
    if (cnt >= nw) begin
      e++;
      if (sum_evictions != '1) sum_evictions++;
      // With no ways at all the incoming line is dropped right away.
      if (cnt == 0) return;
      line_ok[set_i][old_w] = 1'b0;
      free_w = old_w;
    end
    if (free_w < 0) return;
    for (int w = 0; w < MAX_WAYS; w++)
      if (line_ok[set_i][w]) line_age[set_i][w]++;
    line_ok[set_i][free_w] = 1'b1;
    line_tag[set_i][free_w] = tg;
    line_age[set_i][free_w] = 0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    access_outcome_t want;
    int h;
    int m;
    int e;
    if (rst) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        for (int w = 0; w < MAX_WAYS; w++) begin
          line_ok[s][w] = 1'b0;
          line_age[s][w] = 0;
        end
      end
      sum_hits = '0;
      sum_misses = '0;
      sum_evictions = '0;
      cfg_sets = int'(lrucache_pkg::SET_INDEX_BITS_RESET);
      cfg_off = int'(lrucache_pkg::BLOCK_OFFSET_BITS_RESET);
      cfg_ways = int'(lrucache_pkg::WAYS_IN_USE_RESET);
      outcome_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lrucache_pkg::CFG_SET_INDEX_BITS: begin
            cfg_sets = int'(cfg_data[2:0]);
          end
          lrucache_pkg::CFG_BLOCK_OFFSET_BITS: begin
            cfg_off = int'(cfg_data);
          end
          lrucache_pkg::CFG_WAYS_IN_USE: begin
            cfg_ways = int'(cfg_data[3:0]);
          end
          default: begin
          end
        endcase
      end

      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with no access outstanding");
          n_errors++;
        end else begin
          want = outcome_q.pop_front();
          n_checked++;
          check_field("hits", 32'(want.hits), 32'(hits));
          check_field("misses", 32'(want.misses), 32'(misses));
          check_field("evictions", 32'(want.evictions), 32'(evictions));
          check_field("total_hits", want.total_hits, total_hits);
          check_field("total_misses", want.total_misses, total_misses);
          check_field("total_evictions", want.total_evictions, total_evictions);
        end
      end

      if (in_valid && !in_stall) begin
        h = 0;
        m = 0;
        e = 0;
        if (op == lrucache_pkg::OP_LOAD || op == lrucache_pkg::OP_STORE) begin
          cache_access(address, h, m, e);
        end else if (op == lrucache_pkg::OP_MODIFY) begin
          cache_access(address, h, m, e);
          cache_access(address, h, m, e);
        end
        want.hits = 2'(h);
        want.misses = 2'(m);
        want.evictions = 2'(e);
        want.total_hits = sum_hits;
        want.total_misses = sum_misses;
        want.total_evictions = sum_evictions;
        outcome_q.push_back(want);
      end
    end
    errors <= n_errors;
    pending <= outcome_q.size();
    checked <= n_checked;
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int MAX_SET_BITS    = lrucache_pkg::MAX_SET_BITS;
  localparam int MAX_WAYS        = lrucache_pkg::MAX_WAYS;
  localparam int IDLE_LIMIT      = 4000;
  localparam int HOLD_CYCLES     = 400;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int PRESSURE_PHASE  = 7;

  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = lrucache_pkg::CFG_SET_INDEX_BITS;
  logic [5:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = lrucache_pkg::OP_IFETCH;
  logic [63:0] address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  hits;
  logic [1:0]  misses;
  logic [1:0]  evictions;
  logic [31:0] total_hits;
  logic [31:0] total_misses;
  logic [31:0] total_evictions;

  int errors;
  int pending;
  int checked;
  int send_pct = 0;
  int recv_pct = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int cur_sets = int'(lrucache_pkg::SET_INDEX_BITS_RESET);
  int cur_off = int'(lrucache_pkg::BLOCK_OFFSET_BITS_RESET);
  int cur_ways = int'(lrucache_pkg::WAYS_IN_USE_RESET);
  int n_sent = 0;
  int n_settings = 1;
  int idle_count = 0;

  int ph_sets [NUM_PHASES] = '{2, 3, 0, 6, 7, 1, 5, 4, 4, 6};
  int ph_off  [NUM_PHASES] = '{4, 5, 0, 6, 63, 57, 2, 4, 4, 0};
  int ph_ways [NUM_PHASES] = '{2, 4, 8, 8, 15, 3, 0, 8, 1, 9};
  int ph_mode [NUM_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE,
                               IDLE_SENDER, IDLE_RECEIVER, IDLE_NONE, IDLE_BOTH,
                               IDLE_SENDER};

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  lru_set_assoc_cache_tag_sim_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .address(address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hits(hits),
    .misses(misses),
    .evictions(evictions),
    .total_hits(total_hits),
    .total_misses(total_misses),
    .total_evictions(total_evictions)
  );

  lru_cache_checker checker_i (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .address(address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hits(hits),
    .misses(misses),
    .evictions(evictions),
    .total_hits(total_hits),
    .total_misses(total_misses),
    .total_evictions(total_evictions),
    .errors(errors),
    .pending(pending),
    .checked(checked)
  );

  // The long hold-off fires once, so that the block backs up and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else if (idle_count == IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task automatic send_access(input logic [1:0] kind, input logic [63:0] addr);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input int sets, input int offs, input int ways);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= lrucache_pkg::CFG_SET_INDEX_BITS;
    cfg_data <= 6'(sets);
    @(posedge clk);
    cfg_index <= lrucache_pkg::CFG_BLOCK_OFFSET_BITS;
    cfg_data <= 6'(offs);
    @(posedge clk);
    cfg_index <= lrucache_pkg::CFG_WAYS_IN_USE;
    cfg_data <= 6'(ways);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_sets = sets;
    cur_off = offs;
    cur_ways = ways;
    n_settings++;
  endtask

  // Builds an address from a small pool of tags and sets so that lines get reused.
  function automatic logic [63:0] pick_address(input int tag_range, input int set_range);
    logic [63:0] offs;
    logic [63:0] st;
    logic [63:0] tg;
    int          sb;
    int          sh;
    sb = (cur_sets > MAX_SET_BITS) ? MAX_SET_BITS : cur_sets;
    sh = cur_off + sb;
    offs = {$urandom, $urandom} & ((64'd1 << cur_off) - 64'd1);
    st = 64'($urandom_range(set_range - 1)) & ((64'd1 << sb) - 64'd1);
    tg = 64'($urandom_range(tag_range - 1));
    return (tg << sh) | (st << cur_off) | offs;
  endfunction

  initial begin
    int          r;
    int          nw;
    logic [1:0]  kind;
    logic [63:0] a;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_access(lrucache_pkg::OP_IFETCH, 64'h0);
    send_access(lrucache_pkg::OP_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(lrucache_pkg::OP_LOAD, 64'h0);
    send_access(lrucache_pkg::OP_LOAD, 64'h8);
    send_access(lrucache_pkg::OP_STORE, 64'h10);
    send_access(lrucache_pkg::OP_MODIFY, 64'h100);
    send_access(lrucache_pkg::OP_LOAD, 64'h0);
    send_access(lrucache_pkg::OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(lrucache_pkg::OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(lrucache_pkg::OP_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
    send_access(lrucache_pkg::OP_MODIFY, 64'h5555_5555_5555_5555);
    send_access(lrucache_pkg::OP_LOAD, 64'h8000_0000_0000_0000);

    set_config(4, 4, 0);
    send_access(lrucache_pkg::OP_LOAD, 64'h0);
    send_access(lrucache_pkg::OP_MODIFY, 64'h0);
    send_access(lrucache_pkg::OP_STORE, 64'h1234_5678_9ABC_DEF0);

    set_config(7, 63, 15);
    send_access(lrucache_pkg::OP_LOAD, 64'h0);
    send_access(lrucache_pkg::OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(lrucache_pkg::OP_MODIFY, 64'h8000_0000_0000_0000);
    send_access(lrucache_pkg::OP_STORE, 64'h7FFF_FFFF_FFFF_FFFF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_config(ph_sets[p], ph_off[p], ph_ways[p]);
      send_pct = (ph_mode[p] == IDLE_SENDER) ? 73 : (ph_mode[p] == IDLE_BOTH) ? 14 : 0;
      recv_pct = (ph_mode[p] == IDLE_RECEIVER) ? 73 : (ph_mode[p] == IDLE_BOTH) ? 14 : 0;
      if (p == PRESSURE_PHASE) hold_armed = 1'b1;
      nw = (cur_ways > MAX_WAYS) ? MAX_WAYS : cur_ways;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(99);
        kind = (r < 10) ? lrucache_pkg::OP_IFETCH :
               (r < 45) ? lrucache_pkg::OP_LOAD :
               (r < 70) ? lrucache_pkg::OP_STORE : lrucache_pkg::OP_MODIFY;
        if ($urandom_range(99) < 15) a = {$urandom, $urandom};
        else a = pick_address(nw + 2, 3);
        send_access(kind, a);
      end
    end

    drain();
    repeat (2 * MAX_WAYS + 8) @(posedge clk);
    $display("tb: %0d accesses over %0d cache settings, %0d results checked", n_sent,
             n_settings, checked);
    $display("tb: all access kinds, zero to fifteen ways, offsets to 63, one long hold-off");
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
